// ===== rtl/core/bit_symbol_repacker_assert.svh =====
// assertion macros for the bit symbol repacker
`ifndef BIT_SYMBOL_REPACKER_ASSERT_SVH
`define BIT_SYMBOL_REPACKER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define BSR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("bit_symbol_repacker assertion failed");
// consequent must hold in the cycle after the antecedent
`define BSR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bit_symbol_repacker assertion failed");
`else
`define BSR_ASSERT(name, clk, rstn, prop)
`define BSR_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/bsr_pkg.sv =====
// shared types, constants and helper functions of the bit symbol repacker
package bsr_pkg;

  localparam int unsigned ByteBits      = 8;
  localparam int unsigned MaxSymbolBits = 8;

  typedef enum logic [1:0] {
    RegBitsPerSymbol  = 2'd0,
    RegInputMsbFirst  = 2'd1,
    RegOutputMsbFirst = 2'd2
  } reg_idx_e;

  // per-cycle control shared by every cell of the bit row
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // symbol size as used: zero acts as one, anything above the maximum as the maximum
  function automatic logic [3:0] eff_bps(input logic [3:0] raw);
    logic [3:0] b;
    b = raw;
    if (b == 4'd0) begin
      b = 4'd1;
    end else if (b > 4'(MaxSymbolBits)) begin
      b = 4'(MaxSymbolBits);
    end
    return b;
  endfunction

  function automatic logic [ByteBits-1:0] rev8(input logic [ByteBits-1:0] v);
    logic [ByteBits-1:0] r;
    for (int i = 0; i < ByteBits; i++) begin
      r[i] = v[ByteBits-1-i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bsr_cell.sv =====
// one bit cell of the shift row: holds one stream bit and its valid flag
module bsr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsr_pkg::cell_ctrl_t ctrl_i,
  input  logic              load_bit_i,
  input  logic              next_bit_i,
  input  logic              next_valid_i,
  output logic              bit_o,
  output logic              valid_o
);
  import bsr_pkg::*;

  logic bit_q, bit_d;
  logic valid_q, valid_d;

  always_comb begin
    bit_d   = bit_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      bit_d   = load_bit_i;
      valid_d = 1'b1;
    end else if (ctrl_i.shift) begin
      bit_d   = next_bit_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o   = bit_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/core/bsr_asm.sv =====
// symbol assembler: gathers stream bits, packs symbols, holds the output register
module bsr_asm (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] eff_bps_i,
  input  logic       out_msb_first_i,
  input  logic       bps_we_i,
  input  logic [3:0] bps_new_i,
  input  logic       bit_valid_i,
  input  logic       bit_i,
  input  logic       is_last_i,
  input  logic       m_tready_i,
  output logic       advance_o,
  output logic       m_tvalid_o,
  output logic [7:0] m_tdata_o,
  output logic       m_tlast_o
);
  import bsr_pkg::*;
  `include "bit_symbol_repacker_assert.svh"

  logic [6:0] acc_q, acc_d;
  logic [2:0] cnt_q, cnt_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] odata_q, odata_d;
  logic       olast_q, olast_d;

  logic       completes;
  logic [7:0] full;
  logic [7:0] sym;

  assign completes = ({1'b0, cnt_q} + 4'd1) == eff_bps_i;
  assign advance_o = bit_valid_i && !(completes && ovalid_q && !m_tready_i);
  assign full      = {1'b0, acc_q} | (8'(bit_i) << cnt_q);
  // first bit to the top of the symbol: reverse the byte, then right-align
  assign sym       = out_msb_first_i ? (rev8(full) >> (4'(ByteBits) - eff_bps_i)) : full;

  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    olast_d  = olast_q;
    if (bps_we_i) begin
      // leftover bits that no longer fit under the new size are dropped
      if ({1'b0, cnt_q} >= eff_bps(bps_new_i)) begin
        acc_d = '0;
        cnt_d = '0;
      end
    end else if (advance_o) begin
      if (completes) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = full[6:0];
        cnt_d = cnt_q + 3'd1;
      end
    end
    if (advance_o && completes) begin
      ovalid_d = 1'b1;
      odata_d  = sym;
      olast_d  = is_last_i;
    end else if (m_tready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;
  assign m_tlast_o  = olast_q;

  `BSR_ASSERT(a_cnt_below_size, clk_i, rst_ni, ({1'b0, cnt_q} < eff_bps_i))
  `BSR_ASSERT_NEXT(a_symbol_registered, clk_i, rst_ni, (advance_o && completes && !bps_we_i), ovalid_q)

endmodule

// ===== rtl/core/bit_symbol_repacker.sv =====
// top level of the bit symbol repacker: 8-bit input to 1..8-bit symbol gearbox
//
//  channel | group      | fields (lowest bit up)              | per request
//  --------+------------+-------------------------------------+---------------------
//  input   | s_axis_*   | tdata[7:0] in_byte                  | one raw byte
//  output  | m_axis_*   | tdata[7:0] symbol, tlast last_of_byte | one packed symbol
//  config  | cfg_*_i    | idx 0 symbol size, 1 input msb first, 2 output msb first
//
//  a row of eight bit cells shifts one bit per cycle, when not stalled, into the
//  symbol assembler, so bit rate through the row sets the byte rate
//  the next byte loads in the cycle the previous byte's last bit leaves the row
//  up to one symbol per cycle leaves through a registered output stage
//  a stalled output only freezes the row when the bit in cell 0 would finish a symbol
//  reset empties the row and the assembler, the symbol size resets to 1
module bit_symbol_repacker (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol
  output logic       m_axis_tlast,   // last_of_byte
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_wdata_i
);
  import bsr_pkg::*;
  `include "bit_symbol_repacker_assert.svh"

  // configuration registers
  logic [3:0] bps_q, bps_d;
  logic       in_msb_q, in_msb_d;
  logic       out_msb_q, out_msb_d;
  logic       bps_we;

  logic [3:0] eff;

  // bit row
  logic [ByteBits-1:0] row_bit;
  logic [ByteBits-1:0] row_valid;
  logic [ByteBits:0]   valid_ext;   // row valid with an always-empty cell past the end
  logic [ByteBits-1:0] load_byte;
  cell_ctrl_t          ctrl;

  logic advance;
  logic is_last;

  always_comb begin
    bps_d     = bps_q;
    in_msb_d  = in_msb_q;
    out_msb_d = out_msb_q;
    bps_we    = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBitsPerSymbol: begin
          bps_d  = cfg_wdata_i;
          bps_we = 1'b1;
        end
        RegInputMsbFirst:  in_msb_d  = cfg_wdata_i[0];
        RegOutputMsbFirst: out_msb_d = cfg_wdata_i[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q     <= 4'd1;
      in_msb_q  <= 1'b0;
      out_msb_q <= 1'b0;
    end else begin
      bps_q     <= bps_d;
      in_msb_q  <= in_msb_d;
      out_msb_q <= out_msb_d;
    end
  end

  assign eff = eff_bps(bps_q);

  // bit order of the byte fixed at load, cell 0 holds the oldest bit
  assign load_byte = in_msb_q ? rev8(s_axis_tdata) : s_axis_tdata;

  // accept while empty or while the last bit of the current byte shifts out
  assign s_axis_tready = !row_valid[0] || (advance && !row_valid[1]);
  assign ctrl.load     = s_axis_tvalid && s_axis_tready;
  assign ctrl.shift    = advance;

  for (genvar g = 0; g < ByteBits; g++) begin : g_cell
    logic nb, nv;
    if (g == ByteBits - 1) begin : g_end
      assign nb = 1'b0;
      assign nv = 1'b0;
    end else begin : g_mid
      assign nb = row_bit[g+1];
      assign nv = row_valid[g+1];
    end
    bsr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_bit_i   (load_byte[g]),
      .next_bit_i   (nb),
      .next_valid_i (nv),
      .bit_o        (row_bit[g]),
      .valid_o      (row_valid[g])
    );
  end

  // a finished symbol is the byte's last when fewer than a symbol's bits remain behind it;
  // valid cells are contiguous from cell 0, so that is cell eff being empty
  assign valid_ext = {1'b0, row_valid};
  assign is_last   = !valid_ext[eff];

  bsr_asm u_asm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .eff_bps_i       (eff),
    .out_msb_first_i (out_msb_q),
    .bps_we_i        (bps_we),
    .bps_new_i       (cfg_wdata_i),
    .bit_valid_i     (row_valid[0]),
    .bit_i           (row_bit[0]),
    .is_last_i       (is_last),
    .m_tready_i      (m_axis_tready),
    .advance_o       (advance),
    .m_tvalid_o      (m_axis_tvalid),
    .m_tdata_o       (m_axis_tdata),
    .m_tlast_o       (m_axis_tlast)
  );

  `BSR_ASSERT(a_row_contiguous, clk_i, rst_ni, (((row_valid + 8'd1) & row_valid) == 8'd0))
  `BSR_ASSERT(a_no_load_mid_byte, clk_i, rst_ni, (!(row_valid[1] && s_axis_tready)))
  `BSR_ASSERT(a_symbol_upper_zero, clk_i, rst_ni, (!m_axis_tvalid || ((m_axis_tdata >> eff) == 8'd0)))

endmodule
